/* sv/rmez_pkg.sv */
// rmez_pkg: shared types, constants and the cordic angle table for the zxy euler block
// no dependencies
`default_nettype none
package rmez_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN = 24;
    // radicand reaches 2^48 when m11 is zero, so the root needs 25 steps
    localparam int SQRT_STEPS = 25;
    localparam int SW = 50;
    localparam int DW = 40;
    localparam int AW = 33;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;

    typedef enum logic [1:0] {
        GC_NORMAL = 2'd0,
        GC_LOW    = 2'd1,
        GC_HIGH   = 2'd2
    } gimbal_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m11;
        logic signed [15:0] m20;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] z_angle;
        logic signed [15:0] x_angle;
        logic signed [15:0] y_angle;
        logic [1:0]         gimbal_case;
    } ang_t;

    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] r;
        r = '0;
        case (i)
            0: r = 33'sd843314856;   1: r = 33'sd497837829;
            2: r = 33'sd263043836;   3: r = 33'sd133525158;
            4: r = 33'sd67021686;    5: r = 33'sd33543515;
            6: r = 33'sd16775850;    7: r = 33'sd8388437;
            8: r = 33'sd4194282;     9: r = 33'sd2097149;
            10: r = 33'sd1048575;    11: r = 33'sd524287;
            12: r = 33'sd262143;     13: r = 33'sd131071;
            14: r = 33'sd65535;      15: r = 33'sd32767;
            16: r = 33'sd16383;      17: r = 33'sd8191;
            18: r = 33'sd4095;       19: r = 33'sd2047;
            20: r = 33'sd1023;       21: r = 33'sd511;
            22: r = 33'sd255;        23: r = 33'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // q2.30 angle to q3.13, round half away from zero, clamp to +/-pi
    function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] a);
        logic signed [AW:0] m;
        logic signed [AW:0] r;
        m = (a < 0) ? -{a[AW-1], a} : {a[AW-1], a};
        r = (m + (AW+1)'(65536)) >>> 17;
        if (a < 0) r = -r;
        if (r > (AW+1)'(PI_Q13)) r = (AW+1)'(PI_Q13);
        if (r < -(AW+1)'(PI_Q13)) r = -(AW+1)'(PI_Q13);
        return r[15:0];
    endfunction
endpackage
`default_nettype wire

/* sv/rmez_if.sv */
// rmez_if: valid/ready channel carrying one payload
// payload type set by the type parameter T, no package dependency
`default_nettype none
interface rmez_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/rmez_cordic_cell.sv */
// rmez_cordic_cell: one vectoring cordic iteration, registered
// depends on rmez_pkg
`default_nettype none
module rmez_cordic_cell
    import rmez_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] step,
    input  wire vec_t       v_in,
    output vec_t            v_out
);
    vec_t v_reg;
    vec_t v_next;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;

    always_comb
    begin
        xs = v_in.x >>> step;
        ys = v_in.y >>> step;
        if (int'(step) >= TAB_LEN)
        begin
            v_next = v_in;
        end
        else if (v_in.y > 0)
        begin
            v_next.x = v_in.x + ys;
            v_next.y = v_in.y - xs;
            v_next.z = v_in.z + atan_tab(int'(step));
        end
        else
        begin
            v_next.x = v_in.x - ys;
            v_next.y = v_in.y + xs;
            v_next.z = v_in.z - atan_tab(int'(step));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) v_reg <= v_next;
    end
    assign v_out = v_reg;
endmodule
`default_nettype wire

/* sv/rmez_sqrt_cell.sv */
// rmez_sqrt_cell: one bit of the restoring square root, registered
// depends on rmez_pkg
`default_nettype none
module rmez_sqrt_cell
    import rmez_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [4:0]    step,
    input  wire logic [SW-1:0] v_in,
    input  wire logic [SW-1:0] r_in,
    output logic [SW-1:0]      v_out,
    output logic [SW-1:0]      r_out
);
    logic [5:0] sh;
    logic [SW-1:0] b;
    logic [SW-1:0] v_reg, r_reg, v_next, r_next;

    always_comb
    begin
        sh = 6'(2*(SQRT_STEPS-1)) - {step, 1'b0};
        b = SW'(1) << sh;
        if (v_in >= r_in + b)
        begin
            v_next = v_in - (r_in + b);
            r_next = (r_in >> 1) + b;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end
    assign v_out = v_reg;
    assign r_out = r_reg;
endmodule
`default_nettype wire

/* sv/rotation_matrix_to_euler_zxy_top.sv */
// rotation_matrix_to_euler_zxy_top: zxy euler angles from a rotation matrix
// depends on rmez_pkg, rmez_if, rmez_cordic_cell, rmez_sqrt_cell
//
//  channel  | dir | payload                                    | handshake
//  ---------+-----+--------------------------------------------+-----------
//  mat      | in  | m00 m01 m02 m11 m20 m22, signed q2.14      | valid/ready
//  ang      | out | z_angle x_angle y_angle q3.13, gimbal_case | valid/ready
//
// one request per cycle while the output is not stalled; stages in order:
// input register, sqrt cell row, prerotation register, cordic cell row, output register
// the whole pipe advances when the last stage is empty or being taken,
// so a stall at the output freezes every stage, nothing is dropped
// reset clears only the stage valid bits
`default_nettype none
module rotation_matrix_to_euler_zxy_top
    import rmez_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    rmez_if.sink     mat,
    rmez_if.source   ang
);
    localparam int NS = 3 + SQRT_STEPS + CORDIC_STEPS;

    logic adv;
    logic [NS-1:0] vld_reg;
    assign adv = !vld_reg[NS-1] || ang.ready;
    assign mat.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[NS-2:0], mat.valid};
    end

    // stage 0: register the request, radicand (1 - m11^2) scaled by 2^48
    mat_t m_reg;
    logic [SW-1:0] rem_reg;
    logic signed [31:0] sq;
    logic signed [31:0] diff;
    always_comb
    begin
        sq = 32'(mat.data.m11) * 32'(mat.data.m11);
        diff = 32'sd268435456 - sq;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= mat.data;
            rem_reg <= SW'({diff[28:0], 20'd0});
        end
    end

    // sqrt row, matrix carried alongside
    logic [SW-1:0] sv [SQRT_STEPS+1];
    logic [SW-1:0] sr [SQRT_STEPS+1];
    mat_t mp [SQRT_STEPS+1];
    assign sv[0] = rem_reg;
    assign sr[0] = '0;
    assign mp[0] = m_reg;
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        rmez_sqrt_cell u_cell (
            .clk(clk), .en(adv), .step(5'(i)), .v_in(sv[i]), .r_in(sr[i]),
            .v_out(sv[i+1]), .r_out(sr[i+1]));
        always_ff @(posedge clk)
        begin
            if (adv) mp[i+1] <= mp[i];
        end
    end

    // prerotation stage: set up the three vectoring problems
    function automatic vec_t prerot(input logic signed [DW-1:0] y,
                                    input logic signed [DW-1:0] x);
        vec_t v;
        v.x = x; v.y = y; v.z = '0;
        if (x < 0 && y >= 0)
        begin
            v.x = y; v.y = -x; v.z = HALF_PI_Q30;
        end
        else if (x < 0)
        begin
            v.x = -y; v.y = x; v.z = -HALF_PI_Q30;
        end
        v.x = v.x <<< 12;
        v.y = v.y <<< 12;
        return v;
    endfunction

    mat_t mm;
    logic signed [DW-1:0] c_s;
    logic [1:0] gc;
    vec_t v0 [3];
    assign mm = mp[SQRT_STEPS];
    assign c_s = DW'(sr[SQRT_STEPS]);
    always_comb
    begin
        gc = GC_NORMAL;
        if (mm.m11 <= -16'sd16384) gc = GC_LOW;
        else if (mm.m11 >= 16'sd16384) gc = GC_HIGH;
    end

    vec_t p0_reg, p1_reg, p2_reg;
    logic [1:0] gc_pipe [CORDIC_STEPS+1];
    logic zz_pipe [3][CORDIC_STEPS+1];
    logic z0, z1, z2;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (gc == GC_NORMAL)
            begin
                p0_reg <= prerot(-(DW'(mm.m01) <<< 10), DW'(mm.m11) <<< 10);
                p2_reg <= prerot(-(DW'(mm.m20) <<< 10), DW'(mm.m22) <<< 10);
            end
            else
            begin
                p0_reg <= prerot(DW'(mm.m02) <<< 10, DW'(mm.m00) <<< 10);
                p2_reg <= prerot('0, '0);
            end
            p1_reg <= prerot(DW'(mm.m11) <<< 10, c_s);
            gc_pipe[0] <= gc;
            zz_pipe[0][0] <= (gc == GC_NORMAL) ? (mm.m01 == 0 && mm.m11 == 0)
                                               : (mm.m02 == 0 && mm.m00 == 0);
            zz_pipe[1][0] <= 1'b0;
            zz_pipe[2][0] <= (mm.m20 == 0 && mm.m22 == 0);
        end
    end
    assign v0[0] = p0_reg;
    assign v0[1] = p1_reg;
    assign v0[2] = p2_reg;

    // three cordic rows in lock step
    vec_t cv [3][CORDIC_STEPS+1];
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        assign cv[k][0] = v0[k];
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            rmez_cordic_cell u_cell (
                .clk(clk), .en(adv), .step(5'(i)), .v_in(cv[k][i]),
                .v_out(cv[k][i+1]));
            always_ff @(posedge clk)
            begin
                if (adv) zz_pipe[k][i+1] <= zz_pipe[k][i];
            end
        end
    end
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_gc
        always_ff @(posedge clk)
        begin
            if (adv) gc_pipe[i+1] <= gc_pipe[i];
        end
    end

    // final stage: output register
    assign z0 = zz_pipe[0][CORDIC_STEPS];
    assign z1 = zz_pipe[1][CORDIC_STEPS];
    assign z2 = zz_pipe[2][CORDIC_STEPS];
    logic signed [AW-1:0] az, ax, ay;
    logic [1:0] gco;
    ang_t out_reg;
    always_comb
    begin
        gco = gc_pipe[CORDIC_STEPS];
        az = z0 ? '0 : cv[0][CORDIC_STEPS].z;
        ax = z1 ? '0 : cv[1][CORDIC_STEPS].z;
        ay = z2 ? '0 : cv[2][CORDIC_STEPS].z;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.gimbal_case <= gco;
            unique case (gco)
                GC_LOW:
                begin
                    out_reg.z_angle <= to_q13(-az);
                    out_reg.x_angle <= to_q13(HALF_PI_Q30);
                    out_reg.y_angle <= '0;
                end
                GC_HIGH:
                begin
                    out_reg.z_angle <= to_q13(az);
                    out_reg.x_angle <= to_q13(-HALF_PI_Q30);
                    out_reg.y_angle <= '0;
                end
                default:
                begin
                    out_reg.z_angle <= to_q13(-az);
                    out_reg.x_angle <= to_q13(-ax);
                    out_reg.y_angle <= to_q13(-ay);
                end
            endcase
        end
    end
    assign ang.valid = vld_reg[NS-1];
    assign ang.data = out_reg;

    // output never moves while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ang.valid && !ang.ready |=> ang.valid && $stable(ang.data))
        else $error("result changed under stall");
    // gimbal code is never the unused code
    a_gc: assert property (@(posedge clk) disable iff (!rst_n)
        ang.valid |-> ang.data.gimbal_case != 2'd3)
        else $error("bad gimbal code");
    // gimbal results have zero y
    a_gy: assert property (@(posedge clk) disable iff (!rst_n)
        ang.valid && ang.data.gimbal_case != GC_NORMAL |-> ang.data.y_angle == 0)
        else $error("gimbal y not zero");
endmodule
`default_nettype wire
